// ----- hdl/ifrt_pkg.sv -----
`default_nettype none
package ifrt_pkg;
  localparam int SLOTS       = 64;
  localparam int SLOT_W      = 6;
  localparam int PROBE_DEPTH = 8;
  localparam int MAP_WORDS   = 127;
  localparam int WORD_W      = 7;
  localparam int MAP_DEPTH   = SLOTS * MAP_WORDS;
  localparam int MAP_AW      = 13;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_COMPLETE = 3'd2;
  localparam logic [2:0] ST_BOUNDS   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_OVERLAP  = 3'd5;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] datagram_id;
    logic [7:0]  protocol_number;
    logic [12:0] offset_units;
    logic        more_fragments;
    logic [15:0] total_length;
    logic [3:0]  header_words;
    logic [31:0] now_ms;
  } frag_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot_index;
    logic [15:0] datagram_length;
    logic        reclaimed_stale;
  } result_t;

  typedef struct packed {
    logic        active;
    logic [31:0] source;
    logic [31:0] dest;
    logic [15:0] ident;
    logic [7:0]  proto;
    logic [31:0] touched;
    logic        first_seen;
    logic        final_seen;
    logic [15:0] expected_len;
  } slot_t;

  // Bits of word w inside unit range [lo, hi)
  function automatic logic [63:0] word_mask(input logic [6:0] w, input logic [13:0] lo,
                                            input logic [13:0] hi);
    logic [13:0] base;
    logic [13:0] l;
    logic [13:0] h;
    logic [63:0] m;
    base = {w, 7'd0} >> 1;
    l = (lo > base) ? lo - base : 14'd0;
    h = (hi < base + 14'd64) ? hi - base : 14'd64;
    m = '0;
    for (int b = 0; b < 64; b++) begin
      if (14'(b) >= l && 14'(b) < h) m[b] = 1'b1;
    end
    return m;
  endfunction
endpackage
`default_nettype wire

// ----- hdl/ifrt_if.sv -----
`default_nettype none
interface ifrt_frag_if import ifrt_pkg::*; ();
  logic  valid;
  logic  ready;
  frag_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ifrt_result_if import ifrt_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/ipv4_fragment_reassembly_tracker_unit.sv -----
`default_nettype none
// Fragment tracker: one fragment in flight at a time, state held in slot and map RAMs.
// Each fragment probes the slot table, scans and then marks the map words it spans, and
// checks map words for completion; the slot's map is cleared on a claim and on completion.
// A new fragment is taken only once the previous result is in the output register; a result
// held by the sink sits in the output register and stalls only the next result.
// Reset: rst starts a clearing pass of the slot table (no input taken); the map is cleared
// per slot on claim. Timeout resets to 2000 ms.
module ipv4_fragment_reassembly_tracker_unit import ifrt_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_we,
  input  wire logic [15:0] cfg_wdata,
  ifrt_frag_if.sink   frag,
  ifrt_result_if.source result
);
  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_PRD    = 4'd3;
  localparam logic [3:0] S_PEVAL  = 4'd4;
  localparam logic [3:0] S_CLR    = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_SEVAL  = 4'd7;
  localparam logic [3:0] S_MARK   = 4'd8;
  localparam logic [3:0] S_CMPRD  = 4'd9;
  localparam logic [3:0] S_CMPEV  = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  logic [3:0]  state;
  logic [15:0] timeout;
  frag_t       f;
  slot_t       slot_mem [SLOTS];
  slot_t       srd;
  slot_t       sl;
  logic [63:0] map_mem [MAP_DEPTH];
  logic [63:0] mrd;
  logic [SLOT_W-1:0] sidx;
  logic [3:0]  probe;
  logic [6:0]  w;
  logic [6:0]  clr;
  logic [13:0] lo_u;
  logic [13:0] hi_u;
  logic [13:0] units;
  logic        any_old;
  logic        any_new;
  logic        reclaimed;
  logic        clr_then_cmp;
  result_t     res;
  result_t     res_out;
  logic        rvalid;

  logic        s_we;
  logic [SLOT_W-1:0] s_wa;
  slot_t       s_wd;
  logic        m_we;
  logic [MAP_AW-1:0] m_wa;
  logic [63:0] m_wd;
  logic [MAP_AW-1:0] m_ra;
  logic [16:0] plen;
  logic [17:0] endb;
  logic        key_hit;
  logic [31:0] idle;
  logic [63:0] msk;
  logic [63:0] cmask;
  logic [MAP_AW-1:0] base_a;

  assign frag.ready   = (state == S_IDLE);
  assign result.valid = rvalid;
  assign result.data  = res_out;

  assign plen = {1'b0, f.total_length} - {11'd0, f.header_words, 2'b00};
  assign endb = {2'b00, f.offset_units, 3'b000} + {1'b0, plen};
  assign key_hit = srd.active && srd.source == f.source_address &&
                   srd.dest == f.dest_address && srd.ident == f.datagram_id &&
                   srd.proto == f.protocol_number;
  assign idle = f.now_ms - srd.touched;
  assign base_a = MAP_AW'(sidx * MAP_WORDS);
  assign msk = word_mask(w, lo_u, hi_u);
  assign cmask = word_mask(w, 14'd0, units);

  // Memories; forward a map write to a read of the same word in the same cycle
  always_ff @(posedge clk) begin
    if (s_we) slot_mem[s_wa] <= s_wd;
    srd <= slot_mem[sidx];
    if (m_we) map_mem[m_wa] <= m_wd;
    if (m_we && m_wa == m_ra) mrd <= m_wd;
    else mrd <= map_mem[m_ra];
  end

  assign m_ra = base_a + MAP_AW'(w);

  // Control sequencer
  always_ff @(posedge clk) begin
    s_we <= 1'b0;
    m_we <= 1'b0;
    if (rst) begin
      state   <= S_INIT;
      timeout <= TIMEOUT_RESET;
      rvalid  <= 1'b0;
      sidx    <= '0;
      s_we    <= 1'b1;
      s_wa    <= '0;
      s_wd    <= '0;
    end else begin
      if (cfg_we) timeout <= cfg_wdata;
      if (rvalid && result.ready) rvalid <= 1'b0;
      unique case (state)
        S_INIT: begin
          s_we <= 1'b1;
          s_wa <= s_wa + SLOT_W'(1);
          s_wd <= '0;
          if (s_wa == SLOT_W'(SLOTS - 1)) begin
            s_we  <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (frag.valid) begin
            f     <= frag.data;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res.datagram_length <= '0;
          res.reclaimed_stale <= 1'b0;
          res.slot_index <= '0;
          reclaimed <= 1'b0;
          any_old <= 1'b0;
          any_new <= 1'b0;
          lo_u <= {1'b0, f.offset_units};
          hi_u <= {1'b0, f.offset_units} + 14'(({1'b0, plen} + 18'd7) >> 3);
          if (plen[16] || endb > 18'd65535) begin
            res.status <= ST_BOUNDS;
            state <= S_OUT;
          end else begin
            sidx  <= SLOT_W'(f.source_address ^ f.dest_address ^ {16'd0, f.datagram_id}
                     ^ {24'd0, f.protocol_number});
            probe <= '0;
            state <= S_PRD;
          end
        end
        S_PRD: state <= S_PEVAL;
        S_PEVAL: begin
          if (key_hit || !srd.active || idle > {16'd0, timeout}) begin
            sl <= srd;
            if (!key_hit) begin
              reclaimed <= srd.active;
              sl.active <= 1'b1;
              sl.source <= f.source_address;
              sl.dest   <= f.dest_address;
              sl.ident  <= f.datagram_id;
              sl.proto  <= f.protocol_number;
              sl.first_seen <= 1'b0;
              sl.final_seen <= 1'b0;
              sl.expected_len <= '0;
            end
            sl.touched <= f.now_ms;
            clr <= '0;
            clr_then_cmp <= 1'b0;
            state <= key_hit ? S_FIN : S_CLR;
          end else if (probe == 4'(PROBE_DEPTH - 1)) begin
            res.status <= ST_FULL;
            state <= S_OUT;
          end else begin
            probe <= probe + 4'd1;
            sidx  <= sidx + SLOT_W'(1);
            state <= S_PRD;
          end
        end
        S_CLR: begin
          // sweep the slot's map words to zero
          m_we <= 1'b1;
          m_wa <= base_a + MAP_AW'(clr);
          m_wd <= '0;
          clr  <= clr + 7'd1;
          if (clr == 7'(MAP_WORDS - 1)) state <= clr_then_cmp ? S_OUT : S_FIN;
        end
        S_FIN: begin
          // apply flags, then range checks
          if (f.offset_units == '0) sl.first_seen <= 1'b1;
          if (!f.more_fragments) begin
            sl.final_seen <= 1'b1;
            sl.expected_len <= endb[15:0];
          end
          res.slot_index <= sidx;
          res.reclaimed_stale <= reclaimed;
          w <= lo_u[12:6];
          if (hi_u == lo_u) begin
            w <= '0;
            state <= S_CMPRD;
          end else if (((hi_u - 14'd1) >> 6) >= 14'(MAP_WORDS)) begin
            res.status <= ST_OVERLAP;
            s_we <= 1'b1; s_wa <= sidx; s_wd <= sl; s_wd.active <= 1'b0;
            s_wd.touched <= f.now_ms;
            state <= S_OUT;
          end else state <= S_SCAN;
        end
        S_SCAN: state <= S_SEVAL;
        S_SEVAL: begin
          if ((mrd & msk) != 64'd0) any_old <= 1'b1;
          if ((mrd & msk) != msk) any_new <= 1'b1;
          if (14'(w) == ((hi_u - 14'd1) >> 6)) begin
            w <= lo_u[12:6];
            state <= S_MARK;
          end else begin
            w <= w + 7'd1;
            state <= S_SCAN;
          end
        end
        S_MARK: begin
          if (any_old && any_new) begin
            res.status <= ST_OVERLAP;
            s_we <= 1'b1; s_wa <= sidx; s_wd <= sl; s_wd.active <= 1'b0;
            state <= S_OUT;
          end else if (any_old) begin
            w <= '0;
            state <= S_CMPRD;
          end else begin
            // read-modify-write each spanned word in turn, OR-ing in the fragment's bits
            if (!m_we && !clr_then_cmp) begin
              clr_then_cmp <= 1'b1;
            end else if (clr_then_cmp) begin
              m_we <= 1'b1;
              m_wa <= m_ra;
              m_wd <= mrd | msk;
              clr_then_cmp <= 1'b0;
              if (14'(w) == ((hi_u - 14'd1) >> 6)) begin
                w <= '0;
                state <= S_CMPRD;
              end else w <= w + 7'd1;
            end
          end
          units <= 14'(({1'b0, sl.expected_len} + 17'd7) >> 3);
        end
        S_CMPRD: begin
          units <= 14'(({1'b0, sl.expected_len} + 17'd7) >> 3);
          clr_then_cmp <= 1'b0;
          if (!sl.first_seen || !sl.final_seen) begin
            res.status <= any_old ? ST_DUP : ST_STORED;
            s_we <= 1'b1; s_wa <= sidx; s_wd <= sl;
            state <= S_OUT;
          end else state <= S_CMPEV;
        end
        S_CMPEV: begin
          if ({1'b0, w, 6'd0} >= units) begin
            res.status <= ST_COMPLETE;
            res.datagram_length <= sl.expected_len;
            s_we <= 1'b1; s_wa <= sidx; s_wd <= sl;
            s_wd.ident <= '0; s_wd.source <= '0;
            s_wd.first_seen <= 1'b0; s_wd.final_seen <= 1'b0;
            s_wd.expected_len <= '0; s_wd.touched <= f.now_ms;
            clr <= '0;
            clr_then_cmp <= 1'b1;
            state <= S_CLR;
          end else if (w >= 7'(MAP_WORDS) || (mrd & cmask) != cmask) begin
            res.status <= any_old ? ST_DUP : ST_STORED;
            s_we <= 1'b1; s_wa <= sidx; s_wd <= sl;
            state <= S_OUT;
          end else begin
            w <= w + 7'd1;
            state <= S_CMPRD;
          end
        end
        S_OUT: begin
          // hand the result to the output register once it is free
          if (!rvalid || result.ready) begin
            rvalid  <= 1'b1;
            res_out <= res;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // map word read in S_CMPEV relies on S_CMPRD having issued the address
  assert property (@(posedge clk) disable iff (rst) frag.valid && frag.ready |=> state == S_CHECK)
    else $error("accepted fragment not taken up");
  assert property (@(posedge clk) disable iff (rst)
    rvalid && !result.ready |=> rvalid && $stable(res_out))
    else $error("result lost");
  assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && (res.status == ST_BOUNDS || res.status == ST_FULL) |->
    res.slot_index == '0 && !res.reclaimed_stale)
    else $error("slot reported for rejected fragment");
  assert property (@(posedge clk) disable iff (rst) frag.ready |-> !m_we || state == S_IDLE)
    else $error("map write while idle");
endmodule
`default_nettype wire
